[hdl/fnpc_pkg.sv]
// ----------------------------------------------------------------------------
// Fractional-N PLL parameter calculation package
// Shared widths, constants, codes and pipeline payload types.
// ----------------------------------------------------------------------------
package fnpc_pkg;

  localparam int unsigned LO_W            = 33;
  localparam int unsigned REF_W           = 27;
  localparam int unsigned INT_W           = 10;
  localparam int unsigned FRAC_W          = 23;
  localparam int unsigned QUO_W           = INT_W + FRAC_W;
  localparam int unsigned VCO_W           = 33;
  localparam int unsigned DIV_COUNT       = 6;
  localparam int unsigned PROD_W          = LO_W + DIV_COUNT;
  localparam int unsigned CODE_W          = 3;
  localparam int unsigned DVAL_W          = 7;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 33;
  localparam int unsigned REM_W           = REF_W + 1;
  localparam int unsigned WIDE_W          = REF_W + INT_W;
  localparam int unsigned STEPS_PER_STAGE = 3;
  localparam int unsigned DIV_STAGES      = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned LEFT_W          = $clog2(QUO_W + 1);

  localparam logic [VCO_W-1:0] VCO_LOW_HZ  = 33'd2400000000;
  localparam logic [VCO_W-1:0] VCO_HIGH_HZ = 33'd6000000000;

  localparam logic [REF_W-1:0] REF_CLK_RESET = 27'd40000000;
  localparam logic [LO_W-1:0]  MIN_LO_RESET  = 33'd70000000;
  localparam logic [LO_W-1:0]  MAX_LO_RESET  = 33'd6000000000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_NODIV   = 2'd2,
    ST_INTWIDE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_CLK = 2'd0,
    CFG_MIN_LO  = 2'd1,
    CFG_MAX_LO  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [REF_W-1:0] ref_clk;
    logic [LO_W-1:0]  min_lo;
    logic [LO_W-1:0]  max_lo;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic [CODE_W-1:0] code;
    logic [VCO_W-1:0]  vco;
  } sel_t;

  typedef struct packed {
    status_e           status;
    logic [CODE_W-1:0] code;
    logic [REF_W-1:0]  rem;
    logic [QUO_W-1:0]  num;
    logic [LEFT_W-1:0] left;
  } div_t;

endpackage

[hdl/fnpc_if.sv]
// ----------------------------------------------------------------------------
// Fractional-N PLL parameter calculation channels
// Valid/ready channels for LO requests, results and register writes.
// ----------------------------------------------------------------------------
interface fnpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [fnpc_pkg::LO_W-1:0]     lo_freq_hz;

  modport source (output valid, output lo_freq_hz, input ready);
  modport sink   (input valid, input lo_freq_hz, output ready);
endinterface

interface fnpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [fnpc_pkg::STATUS_W-1:0] status;
  logic [fnpc_pkg::CODE_W-1:0]   div_code;
  logic [fnpc_pkg::DVAL_W-1:0]   div_value;
  logic [fnpc_pkg::INT_W-1:0]    int_part;
  logic [fnpc_pkg::FRAC_W-1:0]   frac_part;

  modport source (output valid, output status, output div_code, output div_value,
                  output int_part, output frac_part, input ready);
  modport sink   (input valid, input status, input div_code, input div_value,
                  input int_part, input frac_part, output ready);
endinterface

interface fnpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fnpc_pkg::CFG_IDX_W-1:0]  index;
  logic [fnpc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/frac_n_pll_param_calc_unit.sv]
// Pipeline: 2 front-end stages for range check, divider pick and setup, then 11
// divider stages of 3 restoring steps each, one per quotient bit.
// Throughput: one request per cycle while results are taken; a stalled result
// holds back every full stage behind it.
// Reset: pipeline empties, registers return to 40 MHz reference,
// 70 MHz minimum LO and 6 GHz maximum LO.
// ----------------------------------------------------------------------------
// Fractional-N PLL parameter calculation unit
// Picks the output divider and splits VCO over reference into int and frac.
// ----------------------------------------------------------------------------
module frac_n_pll_param_calc_unit (
  input logic         clk_i,
  input logic         rst_ni,
  fnpc_cfg_if.sink    cfg_i,
  fnpc_in_if.sink     in_i,
  fnpc_out_if.source  out_o
);

  fnpc_pkg::cfg_t cfg_q;
  logic           v   [fnpc_pkg::DIV_STAGES+1];
  fnpc_pkg::div_t d   [fnpc_pkg::DIV_STAGES+1];
  logic           rdy [fnpc_pkg::DIV_STAGES+1];
  fnpc_pkg::div_t fin;
  logic           ok, has_div;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_clk <= fnpc_pkg::REF_CLK_RESET;
      cfg_q.min_lo  <= fnpc_pkg::MIN_LO_RESET;
      cfg_q.max_lo  <= fnpc_pkg::MAX_LO_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        fnpc_pkg::CFG_REF_CLK: cfg_q.ref_clk <= cfg_i.data[fnpc_pkg::REF_W-1:0];
        fnpc_pkg::CFG_MIN_LO:  cfg_q.min_lo  <= cfg_i.data[fnpc_pkg::LO_W-1:0];
        fnpc_pkg::CFG_MAX_LO:  cfg_q.max_lo  <= cfg_i.data[fnpc_pkg::LO_W-1:0];
        default: ;
      endcase
    end
  end

  fnpc_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_i.valid),
    .lo_i    (in_i.lo_freq_hz),
    .ready_o (in_i.ready),
    .valid_o (v[0]),
    .data_o  (d[0]),
    .ready_i (rdy[0])
  );

  for (genvar i = 0; i < fnpc_pkg::DIV_STAGES; i++) begin : g_div
    fnpc_div_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ref_clk_i (cfg_q.ref_clk),
      .valid_i   (v[i]),
      .data_i    (d[i]),
      .ready_o   (rdy[i]),
      .valid_o   (v[i+1]),
      .data_o    (d[i+1]),
      .ready_i   (rdy[i+1])
    );
  end

  assign rdy[fnpc_pkg::DIV_STAGES] = out_o.ready;
  assign fin     = d[fnpc_pkg::DIV_STAGES];
  assign ok      = fin.status == fnpc_pkg::ST_OK;
  assign has_div = ok || fin.status == fnpc_pkg::ST_INTWIDE;

  assign out_o.valid     = v[fnpc_pkg::DIV_STAGES];
  assign out_o.status    = fin.status;
  assign out_o.div_code  = has_div ? fin.code : '0;
  assign out_o.div_value = has_div ? (fnpc_pkg::DVAL_W'(2) << fin.code) : '0;
  assign out_o.int_part  = ok ? fin.num[fnpc_pkg::QUO_W-1:fnpc_pkg::FRAC_W] : '0;
  assign out_o.frac_part = ok ? fin.num[fnpc_pkg::FRAC_W-1:0] : '0;

endmodule

[hdl/fnpc_select.sv]
// ----------------------------------------------------------------------------
// Fractional-N PLL parameter calculation front end
// Range check and divider pick, then overflow check and divider setup.
// ----------------------------------------------------------------------------
module fnpc_select (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fnpc_pkg::cfg_t            cfg_i,
  input  logic                      valid_i,
  input  logic [fnpc_pkg::LO_W-1:0] lo_i,
  output logic                      ready_o,
  output logic                      valid_o,
  output fnpc_pkg::div_t            data_o,
  input  logic                      ready_i
);

  logic                        sel_v_q;
  fnpc_pkg::sel_t              sel_d, sel_q;
  logic                        div_v_q;
  fnpc_pkg::div_t              div_d, div_q;
  logic                        sel_adv, div_adv;
  logic                        in_range, found;
  logic [fnpc_pkg::CODE_W-1:0] code;
  logic [fnpc_pkg::VCO_W-1:0]  vco;
  logic [fnpc_pkg::PROD_W-1:0] prod;
  logic                        wide;

  always_comb begin
    in_range = (lo_i >= cfg_i.min_lo) && (lo_i <= cfg_i.max_lo);
    found    = 1'b0;
    code     = '0;
    vco      = '0;
    for (int k = fnpc_pkg::DIV_COUNT - 1; k >= 0; k--) begin
      prod = fnpc_pkg::PROD_W'(lo_i) << (k + 1);
      if (prod >= fnpc_pkg::PROD_W'(fnpc_pkg::VCO_LOW_HZ) &&
          prod <= fnpc_pkg::PROD_W'(fnpc_pkg::VCO_HIGH_HZ)) begin
        found = 1'b1;
        code  = fnpc_pkg::CODE_W'(k);
        vco   = prod[fnpc_pkg::VCO_W-1:0];
      end
    end
    sel_d.vco = vco;
    if (!in_range) begin
      sel_d.status = fnpc_pkg::ST_RANGE;
      sel_d.code   = '0;
    end else if (!found) begin
      sel_d.status = fnpc_pkg::ST_NODIV;
      sel_d.code   = '0;
    end else begin
      sel_d.status = fnpc_pkg::ST_OK;
      sel_d.code   = code;
    end
  end

  always_comb begin
    wide = {cfg_i.ref_clk, {fnpc_pkg::INT_W{1'b0}}} <= fnpc_pkg::WIDE_W'(sel_q.vco);
    div_d.status = (sel_q.status == fnpc_pkg::ST_OK && wide) ? fnpc_pkg::ST_INTWIDE
                                                              : sel_q.status;
    div_d.code   = sel_q.code;
    div_d.rem    = fnpc_pkg::REF_W'(sel_q.vco >> fnpc_pkg::INT_W);
    div_d.num    = {sel_q.vco[fnpc_pkg::INT_W-1:0], {fnpc_pkg::FRAC_W{1'b0}}};
    div_d.left   = fnpc_pkg::LEFT_W'(fnpc_pkg::QUO_W);
  end

  assign sel_adv = !sel_v_q || div_adv;
  assign div_adv = !div_v_q || ready_i;
  assign ready_o = sel_adv;
  assign valid_o = div_v_q;
  assign data_o  = div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_v_q <= 1'b0;
      div_v_q <= 1'b0;
    end else begin
      if (sel_adv) begin
        sel_v_q <= valid_i;
      end
      if (div_adv) begin
        div_v_q <= sel_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_adv && valid_i) begin
      sel_q <= sel_d;
    end
    if (div_adv && sel_v_q) begin
      div_q <= div_d;
    end
  end

endmodule

[hdl/fnpc_div_stage.sv]
// ----------------------------------------------------------------------------
// Fractional-N PLL parameter calculation divider stage
// A few restoring division steps of VCO over reference, one register stage.
// ----------------------------------------------------------------------------
module fnpc_div_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fnpc_pkg::REF_W-1:0] ref_clk_i,
  input  logic                       valid_i,
  input  fnpc_pkg::div_t             data_i,
  output logic                       ready_o,
  output logic                       valid_o,
  output fnpc_pkg::div_t             data_o,
  input  logic                       ready_i
);

  logic                       valid_q;
  fnpc_pkg::div_t             data_d, data_q;
  logic [fnpc_pkg::REM_W-1:0] trial;
  logic                       qbit;
  logic                       adv;

  always_comb begin
    data_d = data_i;
    trial  = '0;
    qbit   = 1'b0;
    for (int s = 0; s < fnpc_pkg::STEPS_PER_STAGE; s++) begin
      if (data_d.left != '0) begin
        trial = {data_d.rem, data_d.num[fnpc_pkg::QUO_W-1]};
        qbit  = trial >= {1'b0, ref_clk_i};
        if (qbit) begin
          trial = trial - {1'b0, ref_clk_i};
        end
        data_d.rem  = trial[fnpc_pkg::REF_W-1:0];
        data_d.num  = {data_d.num[fnpc_pkg::QUO_W-2:0], qbit};
        data_d.left = data_d.left - fnpc_pkg::LEFT_W'(1);
      end
    end
  end

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
